// ===== sv/gms_pkg.sv =====
// Shared constants, widths and a helper function of the grouped mean/spread block.
package gms_pkg;

  localparam int MAX_REPEATS = 16;
  localparam int MAX_DIMS    = 16;
  localparam int STORE_DEPTH = MAX_REPEATS * MAX_DIMS;

  localparam int SAMPLE_W = 16;
  localparam int REG_W    = 5;
  localparam int DIM_W    = 4;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int TOT_W    = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W    = $clog2(MAX_REPEATS + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(MAX_REPEATS);
  localparam int DEV_W    = SAMPLE_W + 1;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int ACC_W    = SQ_W + $clog2(MAX_REPEATS);
  localparam int ROOT_W   = (ACC_W + 1) / 2;
  localparam int DIV_W    = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;
  localparam int SPREAD_W = 18;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIM    = CFG_IDX_W'(1);

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v,
                                                 input logic [REG_W-1:0] hi);
    logic [REG_W-1:0] r;
    if (v == '0) r = REG_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

// ===== sv/gms_if.sv =====
// Valid/ready channel interfaces for samples and results.
interface gms_in_if import gms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gms_out_if import gms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [DIM_W-1:0]           dim_index;
  logic signed [SAMPLE_W-1:0] mean_value;
  logic [SPREAD_W-1:0]        spread_value;
  logic                       last_result;

  modport source (output valid, output dim_index, output mean_value,
                  output spread_value, output last_result, input ready);
  modport sink   (input valid, input dim_index, input mean_value,
                  input spread_value, input last_result, output ready);
endinterface

// ===== sv/gms_ram.sv =====
// Simple dual-port synchronous RAM with a registered read.
module gms_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/gms_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module gms_div import gms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [REG_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [REG_W-1:0]  rem_r, rem_nxt;
  logic [REG_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REG_W-1:0]  trial;

  // remainder stays below divisor (at most 16), so the trial fits REG_W bits
  always_comb begin
    trial = {rem_r[REG_W-2:0], quo_r[DIV_W-1]};
    if (trial >= dsr_r) begin
      rem_nxt = trial - dsr_r;
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/gms_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module gms_sqrt import gms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ACC_W-1:0]  value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RES_W  = ACC_W + 1;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [ACC_W-1:0]  v_r;
  logic [RES_W-1:0]  res_r;
  logic [ACC_W-1:0]  bit_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [RES_W-1:0]  trial;

  assign trial = res_r + RES_W'(bit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= value;
        res_r  <= '0;
        bit_r  <= ACC_W'(1) << (2 * (ROOT_W - 1));
      end else if (busy_r) begin
        if (RES_W'(v_r) >= trial) begin
          v_r   <= v_r - trial[ACC_W-1:0];
          res_r <= (res_r >> 1) + RES_W'(bit_r);
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

// ===== sv/grouped_mean_spread.sv =====
// Top level: sample store, per-dimension mean/spread sequencer and result register.
//
//  channel  dir  handshake          payload
//  in_bus   in   valid/ready        sample (s16 Q8.8)
//  out_bus  out  valid/ready        dim_index, mean_value, spread_value, last_result
//  cfg_*    in   cfg_we only        cfg_index (0 repeat_count, 1 dim_count), cfg_wdata
//
// Load: one sample per cycle into the store while in_bus.ready is high.
// Compute per dimension (R = repeat count): a sum pass of R store reads, the
// mean divide, a squares pass of R store reads, the square root, the spread
// divide and the write to the result register.
// The divider serves both divides; it and the square-root unit are iterative.
// Synchronous active-low reset clears control state; store contents are not cleared.
// A stalled result register holds the sequencer only at the hand-off to it.
module grouped_mean_spread import gms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  gms_in_if.sink               in_bus,
  gms_out_if.source            out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_LOAD, S_SUM, S_MDIV, S_SQ, S_SQRT, S_SDIV, S_EMIT
  } state_t;

  state_t state_r;

  // configuration, raw and clamped
  logic [REG_W-1:0] rep_r, dim_r;
  logic [REG_W-1:0] reps_c, dims_c;
  logic [TOT_W-1:0] total;

  // load side
  logic [ADDR_W-1:0] load_cnt_r;
  logic              in_fire;
  logic              last_load;

  // pass control
  logic [DIM_W-1:0]  d_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  iss_cnt_r;
  logic [CNT_W-1:0]  got_cnt_r;
  logic              rd_en;
  logic              rvld_r;
  logic              sq_vld_r;
  logic              launched_r;

  // datapath
  logic [SAMPLE_W-1:0]        rd_data;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic signed [DEV_W-1:0]    dev;
  logic signed [2*DEV_W-1:0]  dev_sq;
  logic [SQ_W-1:0]            sq_r;
  logic [ACC_W-1:0]           acc_r;
  logic [ROOT_W-1:0]          root_r;
  logic [SPREAD_W-1:0]        spread_r;
  logic [SUM_W-1:0]           sum_mag;
  logic signed [SAMPLE_W-1:0] mean_q;

  // arithmetic units; the divider serves both divides
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dvd, div_quo;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  // result register
  logic                       out_vld_r;
  logic [DIM_W-1:0]           out_dim_r;
  logic signed [SAMPLE_W-1:0] out_mean_r;
  logic [SPREAD_W-1:0]        out_spread_r;
  logic                       out_last_r;
  logic                       emit_ok;
  logic                       last_dim;

  assign reps_c = clamp_reg(rep_r, REG_W'(MAX_REPEATS));
  assign dims_c = clamp_reg(dim_r, REG_W'(MAX_DIMS));
  assign total  = TOT_W'(reps_c) * TOT_W'(dims_c);

  assign in_bus.ready = (state_r == S_LOAD);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign last_load    = (TOT_W'(load_cnt_r) + TOT_W'(1)) == total;

  // one store read per cycle while a pass still has entries to fetch
  assign rd_en = ((state_r == S_SUM) || (state_r == S_SQ)) && (iss_cnt_r != reps_c);

  gms_ram #(.DEPTH(STORE_DEPTH), .WIDTH(SAMPLE_W)) u_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_cnt_r),
    .wdata (in_bus.sample),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  // mean divide works on the magnitude, sign restored after (truncation toward zero)
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign mean_q  = sum_r[SUM_W-1] ? -SAMPLE_W'(div_quo) : SAMPLE_W'(div_quo);

  assign div_start = ((state_r == S_MDIV) || (state_r == S_SDIV)) && !launched_r;
  assign div_dvd   = (state_r == S_MDIV) ? DIV_W'(sum_mag) : DIV_W'(root_r);
  assign sqrt_start = (state_r == S_SQRT) && !launched_r;

  gms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (reps_c),
    .done     (div_done),
    .quotient (div_quo)
  );

  gms_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (acc_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // squared deviation from the truncated mean; never exceeds 32 bits unsigned
  assign dev    = DEV_W'($signed(rd_data)) - DEV_W'(mean_r);
  assign dev_sq = dev * dev;

  assign emit_ok  = !out_vld_r || out_bus.ready;
  assign last_dim = (d_r == DIM_W'(dims_c - REG_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      rep_r      <= REG_W'(1);
      dim_r      <= REG_W'(1);
      load_cnt_r <= '0;
      iss_cnt_r  <= '0;
      got_cnt_r  <= '0;
      rvld_r     <= 1'b0;
      sq_vld_r   <= 1'b0;
      launched_r <= 1'b0;
      out_vld_r  <= 1'b0;
      d_r        <= '0;
    end else begin
      rvld_r   <= rd_en;
      sq_vld_r <= (state_r == S_SQ) && rvld_r;
      if (rd_en) begin
        addr_r    <= addr_r + ADDR_W'(dims_c);
        iss_cnt_r <= iss_cnt_r + CNT_W'(1);
      end
      if (div_start || sqrt_start) begin
        launched_r <= 1'b1;
      end
      if (out_vld_r && out_bus.ready) begin
        out_vld_r <= 1'b0;
      end

      // any known register write restarts the load
      if (cfg_we && ((cfg_index == REG_REPEAT) || (cfg_index == REG_DIM))) begin
        load_cnt_r <= '0;
        if (cfg_index == REG_REPEAT) begin
          rep_r <= cfg_wdata;
        end else begin
          dim_r <= cfg_wdata;
        end
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (last_load) begin
              load_cnt_r <= '0;
              state_r    <= S_SUM;
              d_r        <= '0;
              addr_r     <= '0;
              iss_cnt_r  <= '0;
              got_cnt_r  <= '0;
              sum_r      <= '0;
            end else begin
              load_cnt_r <= load_cnt_r + ADDR_W'(1);
            end
          end
        end

        S_SUM: begin
          if (rvld_r) begin
            sum_r     <= sum_r + SUM_W'($signed(rd_data));
            got_cnt_r <= got_cnt_r + CNT_W'(1);
            if (got_cnt_r + CNT_W'(1) == reps_c) begin
              state_r    <= S_MDIV;
              launched_r <= 1'b0;
            end
          end
        end

        S_MDIV: begin
          if (div_done) begin
            mean_r    <= mean_q;
            state_r   <= S_SQ;
            addr_r    <= ADDR_W'(d_r);
            iss_cnt_r <= '0;
            got_cnt_r <= '0;
            acc_r     <= '0;
          end
        end

        S_SQ: begin
          if (rvld_r) begin
            sq_r <= dev_sq[SQ_W-1:0];
          end
          if (sq_vld_r) begin
            acc_r     <= acc_r + ACC_W'(sq_r);
            got_cnt_r <= got_cnt_r + CNT_W'(1);
            if (got_cnt_r + CNT_W'(1) == reps_c) begin
              state_r    <= S_SQRT;
              launched_r <= 1'b0;
            end
          end
        end

        S_SQRT: begin
          if (sqrt_done) begin
            root_r     <= sqrt_root;
            state_r    <= S_SDIV;
            launched_r <= 1'b0;
          end
        end

        // spread is staged here; the result register may still hold a waiting beat
        S_SDIV: begin
          if (div_done) begin
            spread_r <= div_quo[SPREAD_W-1:0];
            state_r  <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (emit_ok) begin
            out_vld_r    <= 1'b1;
            out_dim_r    <= d_r;
            out_mean_r   <= mean_r;
            out_spread_r <= spread_r;
            out_last_r   <= last_dim;
            if (last_dim) begin
              state_r <= S_LOAD;
            end else begin
              state_r   <= S_SUM;
              d_r       <= d_r + DIM_W'(1);
              addr_r    <= ADDR_W'(d_r + DIM_W'(1));
              iss_cnt_r <= '0;
              got_cnt_r <= '0;
              sum_r     <= '0;
            end
          end
        end

        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_bus.valid        = out_vld_r;
  assign out_bus.dim_index    = out_dim_r;
  assign out_bus.mean_value   = out_mean_r;
  assign out_bus.spread_value = out_spread_r;
  assign out_bus.last_result  = out_last_r;

  // load counter only runs while loading
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (load_cnt_r == '0))
    else $error("load count nonzero outside load phase");

  // divider finishes only in a state waiting for it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == S_MDIV) || (state_r == S_SDIV)))
    else $error("divider result with no consumer");

  // square root finishes only in its own state
  a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (state_r == S_SQRT))
    else $error("square root result with no consumer");

  // a pass never consumes more store reads than it issued
  a_pass_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SUM) || (state_r == S_SQ)) |-> (got_cnt_r <= iss_cnt_r))
    else $error("store read count out of order");

endmodule

// ===== sim/grouped_mean_spread_tb.sv =====
// Testbench for grouped_mean_spread: directed and random runs checked against a local predictor.
module grouped_mean_spread_tb;
  import gms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Indexes the block does not decode; a write to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  // Longest legal run is a few hundred beats; 5 ms is far past any slow correct run.
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [DIM_W-1:0]           dim;
    logic signed [SAMPLE_W-1:0] mean;
    logic [SPREAD_W-1:0]        spread;
    logic                       last;
  } dim_stats_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  gms_in_if  in_bus();
  gms_out_if out_bus();

  grouped_mean_spread dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: raw register values (clamped on use) and the loaded samples.
  logic [REG_W-1:0]           reps_reg;
  logic [REG_W-1:0]           dims_reg;
  logic signed [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
  int                         fill_count;

  dim_stats_t pending_stats[$];
  int         mismatch_count;
  int         results_seen;
  int         stall_left;
  bit         idle_in;
  bit         idle_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Zero acts as one, anything past the ceiling acts as the ceiling.
  function automatic int eff_count(input logic [REG_W-1:0] raw, input int ceiling);
    if (raw == '0) return 1;
    if (int'(raw) > ceiling) return ceiling;
    return int'(raw);
  endfunction

  function automatic int run_length();
    return eff_count(reps_reg, MAX_REPEATS) * eff_count(dims_reg, MAX_DIMS);
  endfunction

  // Bitwise floor square root; the summed squares stay below 2^37.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int i = 20; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Store one accepted beat; on the last beat of a run queue one result per dimension.
  function automatic void load_sample(input logic signed [SAMPLE_W-1:0] value);
    int              reps;
    int              dims;
    int              sum;
    int              mean;
    longint          dev;
    longint unsigned sq;
    dim_stats_t      res;
    reps = eff_count(reps_reg, MAX_REPEATS);
    dims = eff_count(dims_reg, MAX_DIMS);
    if (fill_count >= reps * dims) fill_count = 0;
    sample_mem[fill_count] = value;
    fill_count++;
    if (fill_count < reps * dims) return;
    fill_count = 0;
    for (int d = 0; d < dims; d++) begin
      sum = 0;
      for (int r = 0; r < reps; r++) sum += int'(sample_mem[r * dims + d]);
      mean = sum / reps;  // truncates toward zero
      sq = 0;
      for (int r = 0; r < reps; r++) begin
        dev = longint'(sample_mem[r * dims + d]) - longint'(mean);
        sq += longint'(dev * dev);
      end
      res.dim    = DIM_W'(d);
      res.mean   = SAMPLE_W'(mean);
      res.spread = SPREAD_W'(floor_root(sq) / longint'(reps));
      res.last   = (d == dims - 1);
      pending_stats.push_back(res);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1, 2, 3, 4: return SAMPLE_W'($urandom);
      // small activations, within +-2.0
      default: return SAMPLE_W'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  // Result side: check each accepted beat, then choose ready for the next cycle.
  initial begin
    dim_stats_t want;
    out_bus.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (pending_stats.size() == 0) begin
          note_mismatch($sformatf("unexpected result dim=%0d mean=%0d spread=%0d last=%0b",
                                  out_bus.dim_index, $signed(out_bus.mean_value),
                                  out_bus.spread_value, out_bus.last_result));
        end else begin
          want = pending_stats.pop_front();
          if (out_bus.dim_index !== want.dim || out_bus.mean_value !== want.mean ||
              out_bus.spread_value !== want.spread || out_bus.last_result !== want.last) begin
            note_mismatch($sformatf(
              {"result %0d: expected dim=%0d mean=%0d spread=%0d last=%0b, ",
               "got dim=%0d mean=%0d spread=%0d last=%0b"},
              results_seen, want.dim, $signed(want.mean), want.spread, want.last,
              out_bus.dim_index, $signed(out_bus.mean_value), out_bus.spread_value,
              out_bus.last_result));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (idle_out && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // One sample beat, with an optional gap in front. Returns in the cycle of acceptance.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    load_sample(value);
  endtask

  // Drop valid, let every queued result drain, then give the store write time to land.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    // any decoded write also throws away a partly loaded run
    if (idx == REG_REPEAT) begin
      reps_reg   = value;
      fill_count = 0;
    end else if (idx == REG_DIM) begin
      dims_reg   = value;
      fill_count = 0;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset values give a 1x1 run: every beat is its own result, mean = sample.
  task automatic test_reset_defaults();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // Extremes across two repeats, then a negative and a positive sum that must truncate toward zero.
  task automatic test_mean_truncation();
    settle();
    write_reg(REG_REPEAT, 5'd2);
    write_reg(REG_DIM, 5'd1);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    settle();
    write_reg(REG_REPEAT, 5'd3);
    write_reg(REG_DIM, 5'd2);
    // repeat-major: dim 0 gets -1, -1, -2; dim 1 gets 5, 6, 6
    send_sample(-16'sd1);
    send_sample(16'sd5);
    send_sample(-16'sd1);
    send_sample(16'sd6);
    send_sample(-16'sd2);
    send_sample(16'sd6);
  endtask

  // A register write in the middle of loading drops the beats loaded so far.
  task automatic test_run_abort();
    settle();
    write_reg(REG_REPEAT, 5'd2);
    write_reg(REG_DIM, 5'd2);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    settle();
    write_reg(REG_DIM, 5'd2);
    send_sample(16'sh0100);
    send_sample(-16'sh0100);
    send_sample(16'sh0300);
    send_sample(16'sh8000);
  endtask

  // Writes to undecoded indexes keep the partial run intact.
  task automatic test_unknown_index();
    send_sample(16'sh1234);
    send_sample(-16'sh4321);
    settle();
    write_reg(REG_SPARE_2, 5'd31);
    write_reg(REG_SPARE_3, 5'd0);
    send_sample(16'sh0f0f);
    send_sample(16'sh5555);
  endtask

  // Zero in both registers behaves as 1x1.
  task automatic test_zero_registers();
    settle();
    write_reg(REG_REPEAT, 5'd0);
    write_reg(REG_DIM, 5'd0);
    send_sample(16'sh0000);
    send_sample(16'shffff);
  endtask

  // Values past the limits clamp to 16 on either axis.
  task automatic test_register_ceiling();
    settle();
    write_reg(REG_REPEAT, 5'd31);
    write_reg(REG_DIM, 5'd0);
    repeat (16) send_sample(pick_sample());
    settle();
    write_reg(REG_REPEAT, 5'd0);
    write_reg(REG_DIM, 5'd31);
    repeat (16) send_sample(pick_sample());
  endtask

  // Mostly complete runs with random shapes; some are cut short or take a spare write.
  task automatic test_random_runs();
    int               beats;
    int               total;
    int               cut;
    int               pick;
    logic [REG_W-1:0] reps_raw;
    logic [REG_W-1:0] dims_raw;
    beats = 0;
    while (beats < 50) begin
      settle();
      if (beats >= 35) begin
        // closing stretch runs at full rate on both sides
        idle_in  = 1'b0;
        idle_out = 1'b0;
      end else begin
        idle_in  = ($urandom_range(0, 2) != 0);
        idle_out = ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        reps_raw = $urandom_range(0, 1) ? REG_W'(16) : REG_W'($urandom_range(17, 31));
        dims_raw = REG_W'($urandom_range(0, 1));
      end else if (pick == 1) begin
        reps_raw = REG_W'($urandom_range(0, 1));
        dims_raw = $urandom_range(0, 1) ? REG_W'(16) : REG_W'($urandom_range(17, 31));
      end else begin
        reps_raw = REG_W'($urandom_range(0, 5));
        dims_raw = REG_W'($urandom_range(1, 4));
      end
      case ($urandom_range(0, 3))
        0: write_reg(REG_REPEAT, reps_raw);
        1: write_reg(REG_DIM, dims_raw);
        default: begin
          write_reg(REG_DIM, dims_raw);
          write_reg(REG_REPEAT, reps_raw);
        end
      endcase
      // keep runs short: a leftover large register with a new large one is rewritten
      if (run_length() > 32) begin
        write_reg(REG_REPEAT, reps_raw);
        write_reg(REG_DIM, dims_raw);
      end
      total = run_length();
      if (total > 1 && $urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, total - 1);
        repeat (cut) send_sample(pick_sample());
        beats += cut;
        if ($urandom_range(0, 1) == 1) begin
          settle();
          write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, REG_W'($urandom));
          repeat (total - cut) send_sample(pick_sample());
          beats += total - cut;
        end
        // otherwise the next phase's register write discards the partial run
      end else begin
        repeat (total) send_sample(pick_sample());
        beats += total;
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_REPEAT;
    cfg_wdata     <= '0;
    in_bus.valid  <= 1'b0;
    in_bus.sample <= '0;
    idle_in        = 1'b1;
    idle_out       = 1'b1;
    reps_reg       = REG_W'(1);
    dims_reg       = REG_W'(1);
    fill_count     = 0;
    mismatch_count = 0;
    results_seen   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_mean_truncation();
    test_run_abort();
    test_unknown_index();
    test_zero_registers();
    test_register_ceiling();
    test_random_runs();

    // drain, then let the sequencer go quiet before judging
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_stats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gms_pkg.sv
sv/gms_if.sv
sv/gms_ram.sv
sv/gms_div.sv
sv/gms_sqrt.sv
sv/grouped_mean_spread.sv
sim/grouped_mean_spread_tb.sv
